// File: hdl/petri_net_transition_firing_top_defines.svh
// ----------------------------------------------------------------------------
// petri net transition firing: assertion macros
// shared property forms used by the engine checks
// ----------------------------------------------------------------------------
`ifndef PETRI_NET_TRANSITION_FIRING_TOP_DEFINES_SVH
`define PETRI_NET_TRANSITION_FIRING_TOP_DEFINES_SVH

// same-cycle implication
`define PNTF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PNTF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pntf_pkg.sv
// ----------------------------------------------------------------------------
// pntf_pkg
// request and response types, operation codes and default sizes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pntf_pkg;

    localparam int PLACES_DEF      = 16;
    localparam int TRANSITIONS_DEF = 16;
    localparam int TOKEN_BITS_DEF  = 16;
    localparam int WEIGHT_BITS     = 16;

    localparam logic [4:0] PLACE_COUNT_RST = 5'd16;

    localparam logic [2:0] OP_LOAD_TOKENS   = 3'd0;
    localparam logic [2:0] OP_LOAD_CONSUMER = 3'd1;
    localparam logic [2:0] OP_LOAD_PRODUCER = 3'd2;
    localparam logic [2:0] OP_FIRE          = 3'd3;
    localparam logic [2:0] OP_READ_TOKENS   = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  place;
        logic [3:0]  transition;
        logic [15:0] value;
    } t_req;

    typedef struct packed {
        logic        fired;
        logic [15:0] token_count;
        logic        saturated;
    } t_rsp;

endpackage

// File: hdl/pntf_ram.sv
// ----------------------------------------------------------------------------
// pntf_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pntf_ram import pntf_pkg::*; #(
    parameter int DEPTH = PLACES_DEF,
    parameter int WIDTH = WEIGHT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/petri_net_transition_firing_top.sv
// ----------------------------------------------------------------------------
// petri_net_transition_firing_top
// a load, an unused operation, or a fire with no active place or with an
// out-of-range transition goes straight from exec to the result; a read
// passes through a read state first; a fire walks the active places once to
// check the enable and, if it is enabled, once more to write the new counts.
// the next request is taken only in idle, so a stalled result holds it off.
// after reset a clearing pass zeroes all PLACES*TRANSITIONS weight entries
// and the marking, one entry a cycle, before the first request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "petri_net_transition_firing_top_defines.svh"

module petri_net_transition_firing_top import pntf_pkg::*; #(
    parameter int PLACES      = PLACES_DEF,
    parameter int TRANSITIONS = TRANSITIONS_DEF,
    parameter int TOKEN_BITS  = TOKEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  t_req       i_req,
    output logic       o_req_stall,
    output logic       o_rsp_valid,
    output t_rsp       o_rsp,
    input  logic       i_rsp_stall,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata
);

    localparam int PW      = $clog2(PLACES);
    localparam int TW      = $clog2(TRANSITIONS);
    localparam int DEPTH_W = PLACES * TRANSITIONS;
    localparam int AW      = $clog2(DEPTH_W);
    localparam int CW      = $clog2(PLACES + 1);
    localparam int SW      = ((TOKEN_BITS > WEIGHT_BITS) ? TOKEN_BITS : WEIGHT_BITS) + 1;
    localparam logic [SW-1:0] TOKEN_MAX = (SW'(1) << TOKEN_BITS) - SW'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CHECK,
        S_UPDATE,
        S_POST
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr;
    logic [CW-1:0]   r_idx;
    logic            r_pend;
    logic            r_ok;
    logic            r_sat;
    logic [4:0]      r_place_count;
    t_req            r_req;
    t_rsp            r_res;
    logic [PW-1:0]   r_widx;
    logic            r_rsp_valid;
    t_rsp            r_rsp;

    logic [CW-1:0]         w_active;
    logic                  w_place_ok;
    logic                  w_trans_ok;
    logic [PW-1:0]         w_pidx;
    logic [TW-1:0]         w_tidx;
    logic [AW-1:0]         w_req_addr;
    logic [AW-1:0]         w_fire_addr;
    logic                  w_issue;
    logic                  w_clr_last;

    logic                  w_mark_we;
    logic [PW-1:0]         w_mark_waddr;
    logic [TOKEN_BITS-1:0] w_mark_wdata;
    logic [PW-1:0]         w_mark_raddr;
    logic [TOKEN_BITS-1:0] w_mark_rdata;
    logic                  w_cw_we;
    logic                  w_pw_we;
    logic [AW-1:0]         w_wt_waddr;
    logic [WEIGHT_BITS-1:0] w_wt_wdata;
    logic [WEIGHT_BITS-1:0] w_cw_rdata;
    logic [WEIGHT_BITS-1:0] w_pw_rdata;

    logic                  w_short;
    logic [SW-1:0]         w_sum;
    logic                  w_clip;
    logic [TOKEN_BITS-1:0] w_new;

    // decode
    assign w_active    = (int'(r_place_count) > PLACES) ? CW'(PLACES) : CW'(r_place_count);
    assign w_place_ok  = int'(r_req.place) < PLACES;
    assign w_trans_ok  = int'(r_req.transition) < TRANSITIONS;
    assign w_pidx      = PW'(r_req.place);
    assign w_tidx      = TW'(r_req.transition);
    assign w_req_addr  = AW'(int'(w_tidx) * PLACES + int'(w_pidx));
    assign w_fire_addr = AW'(int'(w_tidx) * PLACES + int'(r_idx));
    assign w_issue     = r_idx < w_active;
    assign w_clr_last  = int'(r_clr) == DEPTH_W - 1;

    // enable check and count update
    assign w_short = SW'(w_cw_rdata) > SW'(w_mark_rdata);
    assign w_sum   = SW'(w_mark_rdata) - SW'(w_cw_rdata) + SW'(w_pw_rdata);
    assign w_clip  = w_sum > TOKEN_MAX;
    assign w_new   = w_clip ? {TOKEN_BITS{1'b1}} : TOKEN_BITS'(w_sum);

    // memory port steering
    always_comb begin
        w_mark_we    = 1'b0;
        w_mark_waddr = w_pidx;
        w_mark_wdata = TOKEN_BITS'(r_req.value);
        w_mark_raddr = PW'(r_idx);
        w_cw_we      = 1'b0;
        w_pw_we      = 1'b0;
        w_wt_waddr   = w_req_addr;
        w_wt_wdata   = r_req.value;
        unique case (r_state)
            S_CLEAR: begin
                w_mark_we    = int'(r_clr) < PLACES;
                w_mark_waddr = PW'(r_clr);
                w_mark_wdata = '0;
                w_cw_we      = 1'b1;
                w_pw_we      = 1'b1;
                w_wt_waddr   = r_clr;
                w_wt_wdata   = '0;
            end
            S_EXEC: begin
                w_mark_we    = (r_req.operation == OP_LOAD_TOKENS) && w_place_ok;
                w_cw_we      = (r_req.operation == OP_LOAD_CONSUMER) && w_place_ok && w_trans_ok;
                w_pw_we      = (r_req.operation == OP_LOAD_PRODUCER) && w_place_ok && w_trans_ok;
                w_mark_raddr = w_pidx;
            end
            S_UPDATE: begin
                w_mark_we    = r_pend;
                w_mark_waddr = r_widx;
                w_mark_wdata = w_new;
            end
            default: begin
            end
        endcase
    end

    pntf_ram #(
        .DEPTH (PLACES),
        .WIDTH (TOKEN_BITS)
    ) u_marking (
        .i_clk   (i_clk),
        .i_we    (w_mark_we),
        .i_waddr (w_mark_waddr),
        .i_wdata (w_mark_wdata),
        .i_raddr (w_mark_raddr),
        .o_rdata (w_mark_rdata)
    );

    pntf_ram #(
        .DEPTH (DEPTH_W),
        .WIDTH (WEIGHT_BITS)
    ) u_consumer (
        .i_clk   (i_clk),
        .i_we    (w_cw_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (w_wt_wdata),
        .i_raddr (w_fire_addr),
        .o_rdata (w_cw_rdata)
    );

    pntf_ram #(
        .DEPTH (DEPTH_W),
        .WIDTH (WEIGHT_BITS)
    ) u_producer (
        .i_clk   (i_clk),
        .i_we    (w_pw_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (w_wt_wdata),
        .i_raddr (w_fire_addr),
        .o_rdata (w_pw_rdata)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_ok        <= 1'b0;
            r_sat       <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_rsp       <= '0;
        end else begin
            if (r_state == S_POST && (!r_rsp_valid || !i_rsp_stall)) begin
                r_rsp_valid <= 1'b1;
                r_rsp       <= r_res;
            end else if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (w_clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    r_ok   <= 1'b1;
                    r_sat  <= 1'b0;
                    priority if (r_req.operation == OP_READ_TOKENS) begin
                        r_state <= S_READ;
                    end else if (r_req.operation == OP_FIRE && w_trans_ok
                                 && w_active != '0) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_POST;
                    end
                end
                S_READ: begin
                    r_state <= S_POST;
                end
                S_CHECK: begin
                    if (r_pend && w_short) begin
                        r_ok <= 1'b0;
                    end
                    if (w_issue) begin
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= (r_ok && !w_short) ? S_UPDATE : S_POST;
                    end
                end
                S_UPDATE: begin
                    if (r_pend && w_clip) begin
                        r_sat <= 1'b1;
                    end
                    if (w_issue) begin
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (!r_rsp_valid || !i_rsp_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        if ((r_state == S_CHECK || r_state == S_UPDATE) && w_issue) begin
            r_widx <= PW'(r_idx);
        end
        unique case (r_state)
            S_EXEC: begin
                r_res.fired       <= (r_req.operation == OP_FIRE) && w_trans_ok
                                     && (w_active == '0);
                r_res.token_count <= '0;
                r_res.saturated   <= 1'b0;
            end
            S_READ: begin
                r_res.token_count <= w_place_ok ? 16'(w_mark_rdata) : 16'd0;
            end
            S_UPDATE: begin
                if (!w_issue) begin
                    r_res.fired     <= 1'b1;
                    r_res.saturated <= r_sat || (r_pend && w_clip);
                end
            end
            default: begin
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place_count <= PLACE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_place_count <= i_cfg_wdata;
        end
    end

    assign o_req_stall = r_state != S_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `PNTF_ASSERT_NOW(a_check_no_write, i_clk, i_rst_n, r_state == S_CHECK, !w_mark_we && !w_cw_we && !w_pw_we, "memory written during enable check")
    `PNTF_ASSERT_NOW(a_update_in_range, i_clk, i_rst_n, r_state == S_UPDATE && w_mark_we, CW'(r_widx) < w_active, "count write beyond active places")
    `PNTF_ASSERT_NOW(a_sat_needs_fire, i_clk, i_rst_n, r_rsp_valid && r_rsp.saturated, r_rsp.fired, "saturated without firing")
    `PNTF_ASSERT_NOW(a_fire_no_count, i_clk, i_rst_n, r_rsp_valid && r_rsp.fired, r_rsp.token_count == 16'd0, "token count on fire result")
    `PNTF_ASSERT_NEXT(a_post_delivers, i_clk, i_rst_n, r_state == S_POST && (!r_rsp_valid || !i_rsp_stall), r_rsp_valid && r_state == S_IDLE, "result not posted")

endmodule

// File: bench/token_game_checker.sv
// ----------------------------------------------------------------------------
// token_game_checker
// watches the request, response and register ports of the petri net engine,
// keeps its own marking and arc weight tables, predicts one response per
// accepted request and compares every accepted response field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_game_checker import pntf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  t_req       i_req,
    input  logic       i_req_stall,
    input  logic       i_rsp_valid,
    input  t_rsp       i_rsp,
    input  logic       i_rsp_stall,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    output int         o_mismatches,
    output int         o_outstanding
);

    localparam int unsigned TOKEN_MAX = (1 << TOKEN_BITS_DEF) - 1;

    logic [4:0]                active_cfg = PLACE_COUNT_RST;
    logic [TOKEN_BITS_DEF-1:0] marking   [PLACES_DEF];
    logic [WEIGHT_BITS-1:0]    consume_w [PLACES_DEF][TRANSITIONS_DEF];
    logic [WEIGHT_BITS-1:0]    produce_w [TRANSITIONS_DEF][PLACES_DEF];
    t_rsp                      expected_rsp_q[$];
    int                        mismatches = 0;
    int                        rsp_seen   = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at response %0d: %s", rsp_seen, what);
        mismatches++;
    endtask

    function automatic t_rsp token_game_step(input t_req r);
        t_rsp        res;
        int          n;
        bit          enabled;
        int unsigned next_count;
        res = '0;
        n   = (active_cfg > PLACES_DEF) ? PLACES_DEF : int'(active_cfg);
        case (r.operation)
            OP_LOAD_TOKENS:   marking[r.place] = r.value[TOKEN_BITS_DEF-1:0];
            OP_LOAD_CONSUMER: consume_w[r.place][r.transition] = r.value;
            OP_LOAD_PRODUCER: produce_w[r.transition][r.place] = r.value;
            OP_FIRE: begin
                enabled = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (consume_w[i][r.transition] > marking[i]) enabled = 1'b0;
                end
                if (enabled) begin
                    res.fired = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        next_count = 32'(marking[i]);
                        next_count = next_count - 32'(consume_w[i][r.transition])
                                     + 32'(produce_w[r.transition][i]);
                        if (next_count > TOKEN_MAX) begin
                            next_count    = TOKEN_MAX;
                            res.saturated = 1'b1;
                        end
                        marking[i] = next_count[TOKEN_BITS_DEF-1:0];
                    end
                end
            end
            OP_READ_TOKENS:   res.token_count = 16'(marking[r.place]);
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            active_cfg = PLACE_COUNT_RST;
            for (int p = 0; p < PLACES_DEF; p++) begin
                marking[p] = '0;
                for (int t = 0; t < TRANSITIONS_DEF; t++) begin
                    consume_w[p][t] = '0;
                    produce_w[t][p] = '0;
                end
            end
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) active_cfg = i_cfg_wdata;
            if (i_req_valid && !i_req_stall)
                expected_rsp_q.push_back(token_game_step(i_req));
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("response %p with none expected", i_rsp));
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.fired !== want.fired)
                        report_mismatch($sformatf("fired %b, expected %b",
                                                  i_rsp.fired, want.fired));
                    if (i_rsp.token_count !== want.token_count)
                        report_mismatch($sformatf("token_count %h, expected %h",
                                                  i_rsp.token_count, want.token_count));
                    if (i_rsp.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  i_rsp.saturated, want.saturated));
                end
                rsp_seen++;
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_rsp_q.size();
    end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives petri_net_transition_firing_top with a short directed sequence
// (reset state, disabled and saturating fires, full-scale counts, unused
// operations) and then random loads, fires and reads under several active
// place counts and idle patterns, including one long response hold-off;
// the checker predicts and compares, this module only drives and decides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import pntf_pkg::*;

    localparam int         CYCLE_LIMIT       = 600_000;
    localparam int         PHASE_REQUESTS    = 242;
    localparam int         PHASES            = 6;
    localparam int         DRAIN_CYCLES      = 2 * PLACES_DEF + 8;
    localparam int         HOLD_CYCLES       = 400;
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    t_req       req       = '0;
    logic       req_stall;
    logic       rsp_valid;
    t_rsp       rsp;
    logic       rsp_stall = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [4:0] cfg_wdata = '0;

    int          mismatches;
    int          outstanding;
    int unsigned cycles      = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_armed  = 1'b0;
    logic        hold_taken  = 1'b0;
    int          hold_left   = 0;

    petri_net_transition_firing_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_stall (req_stall),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_rsp_stall (rsp_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    token_game_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .i_req_stall   (req_stall),
        .i_rsp_valid   (rsp_valid),
        .i_rsp         (rsp),
        .i_rsp_stall   (rsp_stall),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // response side: random stalls plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall  <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            rsp_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("** petri_net_transition_firing_top: FAILED **");
        $finish;
    end

    function automatic t_req request_of(input logic [2:0] op, input logic [3:0] place,
                                        input logic [3:0] transition, input logic [15:0] value);
        t_req r;
        r.operation  = op;
        r.place      = place;
        r.transition = transition;
        r.value      = value;
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   shape;
        pick         = $urandom_range(0, 99);
        shape        = $urandom_range(0, 9);
        r.place      = 4'($urandom_range(0, 15));
        r.transition = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                                  : 4'($urandom_range(0, 15));
        r.value      = 16'($urandom);
        if (pick < 18) begin
            r.operation = OP_LOAD_TOKENS;
            if (shape < 4)      r.value = 16'($urandom_range(0, 15));
            else if (shape > 6) r.value = 16'hFFFF - 16'($urandom_range(0, 15));
        end else if (pick < 38) begin
            r.operation = OP_LOAD_CONSUMER;
            if (shape < 4)      r.value = '0;
            else if (shape < 8) r.value = 16'($urandom_range(1, 4));
        end else if (pick < 56) begin
            r.operation = OP_LOAD_PRODUCER;
            if (shape < 5)      r.value = 16'($urandom_range(0, 4));
            else if (shape > 7) r.value = 16'hFFFF - 16'($urandom_range(0, 15));
        end else if (pick < 80) begin
            r.operation = OP_FIRE;
        end else if (pick < 94) begin
            r.operation = OP_READ_TOKENS;
        end else begin
            r.operation = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic write_place_count(input logic [4:0] count);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial begin
        t_req       directed[$];
        logic [4:0] phase_cfg [PHASES];

        phase_cfg[0] = 5'd0;
        phase_cfg[1] = 5'd31;
        phase_cfg[2] = 5'd1;
        phase_cfg[3] = 5'($urandom_range(2, 15));
        phase_cfg[4] = 5'd17;
        phase_cfg[5] = PLACE_COUNT_RST;

        // reset state, disabled fire, saturation, full-scale weights
        directed.push_back(request_of(OP_READ_TOKENS,   4'd0,  4'd0,  16'h0000));
        directed.push_back(request_of(OP_FIRE,          4'd0,  4'd0,  16'h0000));
        directed.push_back(request_of(OP_LOAD_TOKENS,   4'd15, 4'd0,  16'hFFFF));
        directed.push_back(request_of(OP_READ_TOKENS,   4'd15, 4'd0,  16'h0000));
        directed.push_back(request_of(OP_LOAD_CONSUMER, 4'd0,  4'd1,  16'd5));
        directed.push_back(request_of(OP_FIRE,          4'd0,  4'd1,  16'h0000));
        directed.push_back(request_of(OP_LOAD_TOKENS,   4'd0,  4'd0,  16'd5));
        directed.push_back(request_of(OP_LOAD_PRODUCER, 4'd15, 4'd1,  16'd1));
        directed.push_back(request_of(OP_FIRE,          4'd0,  4'd1,  16'h0000));
        directed.push_back(request_of(OP_FIRE,          4'd0,  4'd1,  16'h0000));
        directed.push_back(request_of(OP_LOAD_PRODUCER, 4'd3,  4'd15, 16'hFFFF));
        directed.push_back(request_of(OP_FIRE,          4'd0,  4'd15, 16'h0000));
        directed.push_back(request_of(OP_FIRE,          4'd0,  4'd15, 16'h0000));
        directed.push_back(request_of(OP_READ_TOKENS,   4'd3,  4'd0,  16'h0000));
        directed.push_back(request_of(OP_LOAD_CONSUMER, 4'd15, 4'd15, 16'hFFFF));
        directed.push_back(request_of(OP_FIRE,          4'd0,  4'd15, 16'h0000));
        directed.push_back(request_of(OP_READ_TOKENS,   4'd15, 4'd0,  16'h0000));
        directed.push_back(request_of(OP_LOAD_TOKENS,   4'd7,  4'd0,  16'hAAAA));
        directed.push_back(request_of(OP_READ_TOKENS,   4'd7,  4'd0,  16'h0000));
        directed.push_back(request_of(OP_LOAD_TOKENS,   4'd7,  4'd0,  16'h5555));
        directed.push_back(request_of(OP_READ_TOKENS,   4'd7,  4'd0,  16'h0000));
        for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
            directed.push_back(request_of(3'(op), 4'd15, 4'd15, 16'hFFFF));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_place_count(PLACE_COUNT_RST);
        foreach (directed[i]) send_request(directed[i]);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_idle_pct  = (ph < 2) ? 37 : (ph < 4) ? 47 : 0;
            rx_idle_pct <= (ph < 2) ? 47 : (ph < 4) ? 37 : 0;
            write_place_count(phase_cfg[ph]);
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                if (ph == 4 && k == 40) hold_armed <= 1'b1;
                send_request(random_request());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("** petri_net_transition_firing_top: PASSED **");
        end else begin
            $display("** petri_net_transition_firing_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/pntf_pkg.sv
hdl/pntf_ram.sv
hdl/petri_net_transition_firing_top.sv
bench/token_game_checker.sv
bench/testbench.sv
